>>> sv/bia_pkg.sv
// ----------------------------------------------------------------------------
// bia_pkg
// Shared constants and codes for the bitmap ID allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bia_pkg;

    // Number of IDs the bitmap can track.
    localparam int POOL_SIZE = 256;

    localparam int ID_W     = 32;
    localparam int STATUS_W = 2;

    // Bitmap is stored as words in a RAM, one summary flop per word.
    localparam int WORD_W = (POOL_SIZE < 32) ? POOL_SIZE : 32;
    localparam int NWORDS = (POOL_SIZE + WORD_W - 1) / WORD_W;
    localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BIT_W  = $clog2(WORD_W);
    localparam int OFF_W  = WIDX_W + BIT_W;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ID_END   = CFG_IDX_W'(1);
    localparam logic [ID_W-1:0] ID_START_RST = ID_W'(0);
    localparam logic [ID_W-1:0] ID_END_RST   = ID_W'(255);

    // Request codes
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADCFG = 2'd3;

    typedef logic [ID_W-1:0]     t_id;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [WIDX_W-1:0]   t_widx;
    typedef logic [BIT_W-1:0]    t_bidx;

endpackage

`default_nettype wire

>>> sv/bitmap_id_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_id_allocator
// Lowest-free ID allocator over a configurable range, bitmap kept in RAM.
// ----------------------------------------------------------------------------
// Flow: a request transfers in while IDLE, which issues the bitmap word read;
//   MOD modifies and writes back the word and registers the result once the
//   output register is free. No new request is taken until back in IDLE.
// Reset: config returns to id_start 0 / id_end 255; per-word valid flops are
//   cleared so every bitmap word reads as all-free; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_id_allocator (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // config write port
    input  wire                          i_cfg_we,
    input  wire [bia_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [bia_pkg::ID_W-1:0]      i_cfg_wdata,
    // request channel
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_action,
    input  wire [bia_pkg::ID_W-1:0]      i_id_value,
    // result channel
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [bia_pkg::STATUS_W-1:0] o_status,
    output logic [bia_pkg::ID_W-1:0]     o_granted_id
);

    import bia_pkg::*;

    // Two-phase sequencer: IDLE issues the RAM read, MOD modifies/writes back.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_MOD  = 1'b1;

    logic r_state, n_state;

    // Config registers
    t_id r_id_start, r_id_end;

    // Per-word summary: all bits used; per-word valid: written since reset
    logic [NWORDS-1:0] r_full, n_full;
    logic [NWORDS-1:0] r_row_vld, n_row_vld;

    // Request captured at transfer
    logic  r_act;
    t_id   r_idv;
    t_bidx r_rel_bit;
    t_widx r_word;       // word being read / written back
    logic  r_any_free;   // some word not full at request time
    logic  r_word_vld;   // row valid of r_word at read time

    // Output register
    logic    r_out_valid, n_out_valid;
    t_status r_status;
    t_id     r_granted;

    // ------------------------------------------------------------------
    // Accept side: pick the word to read
    // ------------------------------------------------------------------
    logic  in_xfer;
    t_widx free_word;
    logic  any_free;
    t_id   rel_off;
    t_widx rd_word;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    // lowest word with at least one free bit
    always_comb begin
        free_word = '0;
        any_free  = 1'b0;
        for (int w = NWORDS - 1; w >= 0; w--) begin
            if (!r_full[w]) begin
                free_word = WIDX_W'(w);
                any_free  = 1'b1;
            end
        end
    end

    assign rel_off = i_id_value - r_id_start;
    assign rd_word = (i_action == ACT_ALLOC) ? free_word : rel_off[BIT_W +: WIDX_W];

    // ------------------------------------------------------------------
    // Modify side
    // ------------------------------------------------------------------
    t_word ram_rdata, rd_word_data, wr_data;
    t_bidx zero_bit;
    logic [OFF_W-1:0] alloc_off;
    t_id   span_m1;
    logic  cfg_ok, alloc_ok, rel_in_range, can_load, ram_we;
    t_status res_status;
    t_id     res_granted;

    // unwritten words read as all free
    assign rd_word_data = r_word_vld ? ram_rdata : '0;

    // lowest zero bit of the word
    always_comb begin
        zero_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!rd_word_data[b]) begin
                zero_bit = BIT_W'(b);
            end
        end
    end

    assign alloc_off    = {r_word, zero_bit};
    assign span_m1      = r_id_end - r_id_start;
    assign cfg_ok       = (r_id_start <= r_id_end) && (span_m1 < ID_W'(POOL_SIZE));
    assign alloc_ok     = r_any_free && (ID_W'(alloc_off) <= span_m1);
    assign rel_in_range = (r_idv >= r_id_start) && (r_idv <= r_id_end);
    assign can_load     = !r_out_valid || i_out_ready;

    always_comb begin
        res_status  = ST_OK;
        res_granted = '0;
        ram_we      = 1'b0;
        wr_data     = rd_word_data;
        if (!cfg_ok) begin
            res_status = ST_BADCFG;
        end else if (r_act == ACT_ALLOC) begin
            if (alloc_ok) begin
                ram_we            = 1'b1;
                wr_data[zero_bit] = 1'b1;
                res_granted       = r_id_start + ID_W'(alloc_off);
            end else begin
                res_status = ST_FULL;
            end
        end else begin
            if (rel_in_range) begin
                ram_we             = 1'b1;
                wr_data[r_rel_bit] = 1'b0;
            end else begin
                res_status = ST_RANGE;
            end
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    logic do_commit;
    assign do_commit = (r_state == S_MOD) && can_load;

    always_comb begin
        n_state     = r_state;
        n_full      = r_full;
        n_row_vld   = r_row_vld;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                // hold the read word until the output register frees up
                if (can_load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    if (ram_we) begin
                        n_full[r_word]    = &wr_data;
                        n_row_vld[r_word] = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_full      <= '0;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
            r_id_start  <= ID_START_RST;
            r_id_end    <= ID_END_RST;
        end else begin
            r_state     <= n_state;
            r_full      <= n_full;
            r_row_vld   <= n_row_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ID_START: r_id_start <= i_cfg_wdata;
                    CFG_ID_END:   r_id_end   <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_act      <= i_action;
            r_idv      <= i_id_value;
            r_rel_bit  <= rel_off[BIT_W-1:0];
            r_word     <= rd_word;
            r_any_free <= any_free;
            r_word_vld <= r_row_vld[rd_word];
        end
        if (do_commit) begin
            r_status  <= res_status;
            r_granted <= res_granted;
        end
    end

    // ------------------------------------------------------------------
    // Bitmap storage
    // ------------------------------------------------------------------
    bia_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (do_commit && ram_we),
        .i_waddr (r_word),
        .i_wdata (wr_data),
        .i_re    (in_xfer),
        .i_raddr (rd_word),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_granted_id = r_granted;

endmodule

`default_nettype wire

>>> sv/bia_ram.sv
// ----------------------------------------------------------------------------
// bia_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire                                         i_clk,
    input  wire                                         i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                             i_wdata,
    input  wire                                         i_re,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bitmap_id_allocator. Requests go in through a
// valid/ready channel with random gaps, results are drained with random
// back-pressure. A behavioral copy of the ID bitmap predicts every result and
// a scoreboard compares it field by field, in order. The pool range is
// reprogrammed between phases while the block is quiet.
// ----------------------------------------------------------------------------

module tb_top;
    import bia_pkg::*;

    localparam int unsigned RUN_LIMIT_NS = 5_000_000;
    localparam int          TARGET_ITEMS = 2000;
    localparam int          QUIET_ITEMS  = 1750;   // no idling past this point
    localparam int          SETTLE_CYC   = 4;

    // Indexes past the register list; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    typedef struct packed {
        t_status status;
        t_id     granted_id;
    } t_grant;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own bitmap and range registers, predicts the
    // result of every request as it transfers in, checks results in order.
    // ------------------------------------------------------------------------
    class alloc_scoreboard;
        t_id    id_start;
        t_id    id_end;
        bit     used [POOL_SIZE];
        t_grant pending_grants [$];
        int     mismatches;

        function new();
            id_start   = ID_START_RST;
            id_end     = ID_END_RST;
            mismatches = 0;
            foreach (used[k]) used[k] = 1'b0;
        endfunction

        function void flag(string msg);
            if (mismatches < 10) $display("%s", msg);
            mismatches++;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, t_id data);
            if (idx == CFG_ID_START) id_start = data;
            else if (idx == CFG_ID_END) id_end = data;
        endfunction

        // Number of IDs in the pool, 0 when the range is unusable.
        function longint unsigned live_span();
            longint unsigned n;
            if (id_start > id_end) return 0;
            n = longint'(id_end) - longint'(id_start) + 1;
            if (n > POOL_SIZE) return 0;
            return n;
        endfunction

        function void note_request(logic act, t_id idv);
            t_grant          g;
            longint unsigned n;
            int              i;
            bit              found;
            g.status     = ST_OK;
            g.granted_id = '0;
            n            = live_span();
            found        = 1'b0;
            if (n == 0) begin
                g.status = ST_BADCFG;
            end else if (act == ACT_ALLOC) begin
                // lowest free offset wins
                g.status = ST_FULL;
                for (i = 0; i < n && !found; i++) begin
                    if (!used[i]) begin
                        used[i]      = 1'b1;
                        g.granted_id = id_start + t_id'(i);
                        g.status     = ST_OK;
                        found        = 1'b1;
                    end
                end
            end else if (idv < id_start || idv > id_end) begin
                g.status = ST_RANGE;
            end else begin
                used[idv - id_start] = 1'b0;   // freeing a free ID is harmless
            end
            pending_grants.push_back(g);
        endfunction

        function void check_result(t_status st, t_id gid);
            t_grant want;
            if (pending_grants.size() == 0) begin
                flag($sformatf("%0t: result with nothing outstanding: status %0d id %h",
                               $realtime, st, gid));
                return;
            end
            want = pending_grants.pop_front();
            if (st !== want.status)
                flag($sformatf("%0t: status mismatch: expected %0d got %0d",
                               $realtime, want.status, st));
            if (gid !== want.granted_id)
                flag($sformatf("%0t: granted_id mismatch: expected %h got %h",
                               $realtime, want.granted_id, gid));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_ID_START;
    t_id                  i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic                 i_action    = ACT_ALLOC;
    t_id                  i_id_value  = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_status              o_status;
    t_id                  o_granted_id;

    alloc_scoreboard sb = new();
    bit              gaps_on = 1'b1;   // random idling on both channels
    int              sent    = 0;      // requests transferred so far
    int unsigned     stall_left = 0;

    bitmap_id_allocator i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_id_value   (i_id_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_granted_id (o_granted_id)
    );

    always #5 i_clk = ~i_clk;

    // Result side: ready drops in random bursts while idling is on.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 9);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Every result transfer is checked against the oldest prediction.
    // All drives are nonblocking, so these are the pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_granted_id);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // One request; returns at the edge where it transferred, valid still high
    // so back-to-back requests need no extra cycle.
    task automatic send_request(logic act, t_id idv);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_id_value <= idv;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(act, idv);
        sent++;
    endtask

    // Stop sending and wait until every predicted result has come back,
    // then let the pipeline settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_grants.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Holds the write enable; the caller drops it after the last write.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, t_id data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_pool(t_id first_id, t_id last_id);
        drain_results();
        cfg_write(CFG_ID_START, first_id);
        cfg_write(CFG_ID_END, last_id);
        i_cfg_we <= 1'b0;
    endtask

    // Release target: mostly IDs currently held, some free in-range ones,
    // some just past either end of the range, some anywhere.
    function automatic t_id pick_release_id();
        longint unsigned n;
        int              r;
        int              base;
        int              j;
        n = sb.live_span();
        r = $urandom_range(0, 99);
        if (n == 0 || r >= 90) return $urandom;
        if (r < 80) begin
            if (r < 60) begin
                base = $urandom_range(0, int'(n - 1));
                for (j = 0; j < n; j++)
                    if (sb.used[(base + j) % n]) return sb.id_start + t_id'((base + j) % n);
            end
            return sb.id_start + t_id'($urandom_range(0, int'(n - 1)));
        end
        return $urandom_range(0, 1) ? sb.id_start - 1 : sb.id_end + 1;
    endfunction

    // New range for a random phase; returns 1 when the range is unusable.
    task automatic pick_pool(output bit bad);
        t_id         first_id;
        t_id         last_id;
        int unsigned len;
        bad = 1'b0;
        len = 1;
        first_id = $urandom;
        case ($urandom_range(0, 5))
            0: len = $urandom_range(1, 16);
            1: len = POOL_SIZE;
            2: len = $urandom_range(17, POOL_SIZE - 1);
            3: begin
                len      = $urandom_range(1, POOL_SIZE);
                first_id = '1 - t_id'(len - 1);        // range ends at the top ID
            end
            4: begin
                len      = $urandom_range(1, POOL_SIZE);
                first_id = '0;
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            if ($urandom_range(0, 1)) begin
                // start above end
                first_id = $urandom_range(1, 32'hFFFF_FFFF);
                last_id  = $urandom_range(0, first_id - 1);
            end else begin
                // one ID too many, or far too many
                first_id = $urandom_range(0, 1000);
                last_id  = first_id + POOL_SIZE + $urandom_range(0, 100000);
            end
        end else begin
            if (first_id > '1 - t_id'(len - 1)) first_id = '1 - t_id'(len - 1);
            last_id = first_id + t_id'(len - 1);
        end
        set_pool(first_id, last_id);
    endtask

    task automatic run_phase(int items, int alloc_pct);
        int k;
        for (k = 0; k < items; k++) begin
            if ($urandom_range(0, 99) < alloc_pct) send_request(ACT_ALLOC, $urandom);
            else send_request(ACT_RELEASE, pick_release_id());
            if (sent >= QUIET_ITEMS) gaps_on = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        bit bad;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset range 0..255
        send_request(ACT_ALLOC, 32'hFFFF_FFFF);   // -> 0, payload ignored
        send_request(ACT_ALLOC, '0);              // -> 1
        send_request(ACT_RELEASE, 32'd0);
        send_request(ACT_RELEASE, 32'd0);         // already free
        send_request(ACT_ALLOC, '0);              // -> 0 again
        send_request(ACT_RELEASE, 32'd256);       // just above the range
        send_request(ACT_RELEASE, 32'hFFFF_FFFF);
        send_request(ACT_RELEASE, 32'd255);       // top of range, free

        // Four IDs at the very top; offsets 0 and 1 are still held
        set_pool(32'hFFFF_FFFC, 32'hFFFF_FFFF);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '0);              // pool full
        send_request(ACT_RELEASE, 32'hFFFF_FFFB); // just below the range
        send_request(ACT_RELEASE, 32'hFFFF_FFFC);
        send_request(ACT_ALLOC, '0);

        // Unusable ranges
        set_pool(32'd10, 32'd9);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_RELEASE, 32'd10);
        set_pool(32'd0, 32'd256);
        send_request(ACT_ALLOC, '0);
        set_pool(32'd0, 32'hFFFF_FFFF);
        send_request(ACT_RELEASE, 32'd3);

        // Single-ID pool
        set_pool(32'd5, 32'd5);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_RELEASE, 32'd5);
        send_request(ACT_ALLOC, '0);

        // Writes past the register list must not disturb anything
        drain_results();
        cfg_write(CFG_SPARE_A, $urandom);
        cfg_write(CFG_SPARE_B, $urandom);
        i_cfg_we <= 1'b0;
        set_pool(ID_START_RST, ID_END_RST);
        run_phase(40, 50);

        // Random phases, each under a fresh range
        while (sent < TARGET_ITEMS) begin
            pick_pool(bad);
            run_phase(bad ? 20 : 220, $urandom_range(35, 75));
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.pending_grants.size() != 0)
            sb.flag($sformatf("%0d expected results never arrived",
                              sb.pending_grants.size()));
        if (sb.mismatches == 0) begin
            $display("bitmap_id_allocator regression: pass");
        end else begin
            $display("bitmap_id_allocator regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("bitmap_id_allocator regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
sv/bia_pkg.sv
sv/bia_ram.sv
sv/bitmap_id_allocator.sv
verif/tb_top.sv
